// ===== hdl/tlbpt_pkg.sv =====
// shared types, constants and helpers for the tlb / page table / cache simulator
// no dependencies
`timescale 1ns / 1ps

package tlbpt_pkg;

  localparam int DEF_MAX_TLB_ENTRIES = 16;
  localparam int DEF_MAX_FRAMES      = 64;
  localparam int DEF_MAX_SETS        = 256;
  localparam int DEF_MAX_WAYS        = 8;
  localparam int DEF_ADDR_WIDTH      = 32;

  localparam int VA_W     = 32;
  localparam int TS_W     = 32;
  localparam int PA_OUT_W = 22;
  localparam int CFG_IW   = 3;
  localparam int CFG_DW   = 7;

  // configuration register indexes
  localparam logic [CFG_IW-1:0] CFG_PAGE_BITS  = 3'd0;
  localparam logic [CFG_IW-1:0] CFG_BLOCK_BITS = 3'd1;
  localparam logic [CFG_IW-1:0] CFG_SET_BITS   = 3'd2;
  localparam logic [CFG_IW-1:0] CFG_WAYS       = 3'd3;
  localparam logic [CFG_IW-1:0] CFG_TLB_N      = 3'd4;
  localparam logic [CFG_IW-1:0] CFG_FRAMES_N   = 3'd5;

  typedef enum logic [1:0] {
    LK_SKIP  = 2'd0,
    LK_HIT   = 2'd1,
    LK_FILL  = 2'd2,
    LK_EVICT = 2'd3
  } lookup_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_UPD,
    ST_SWEEP,
    ST_LOOK,
    ST_CWR,
    ST_DONE
  } ctrl_state_t;

  typedef struct packed {
    logic clr;
    logic load;
    logic scan;
    logic upd;
    logic sweep;
    logic look;
    logic ca_clr;
    logic cwr;
    logic outld;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic scan_done;
    logic sweep_done;
    logic look_done;
    logic out_free;
  } dp_sts_t;

  function automatic int idx_w(input int n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

// ===== hdl/tlb_page_table_cache_lru_sim.sv =====
// top level of the tlb, inverted page table and lru cache simulator
// depends on tlbpt_pkg, tlbpt_ctrl, tlbpt_dp (which uses tlbpt_ram)
`timescale 1ns / 1ps

// usage
//  - in channel: in_valid/in_ready carry one request (virtual address, timestamp)
//  - out channel: out_valid/out_ready carry one result per request: physical
//    address, tlb hit, page table outcome and cache hit
//  - cfg port: cfg_we writes cfg_wdata into register cfg_index at once; write
//    only while no request is in flight
//  - after reset the cache line ram is cleared one line per cycle, all
//    MAX_SETS*MAX_WAYS lines (2048 by default); in_ready stays low meanwhile
//  - per request: tlb and frame table are scanned together, one entry per
//    cycle, over max(tlb entries, frames) entries; a table update; a sweep
//    over the sets*ways lines of the line ram only when a frame is evicted;
//    a lookup over the ways of the set; a cache line write and a load of the
//    result register
//  - with the reset settings and no eviction the scan over the frame ram
//    port sets the pace; one request at a time, so a new request is taken
//    only after the previous one has been loaded into the result register
//  - the result register lets the next request enter while the previous
//    result waits; a stalled receiver holds the finished request in its
//    last step until the register frees up
module tlb_page_table_cache_lru_sim
  import tlbpt_pkg::*;
#(
  parameter int MAX_TLB_ENTRIES = DEF_MAX_TLB_ENTRIES,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
  parameter int MAX_SETS        = DEF_MAX_SETS,
  parameter int MAX_WAYS        = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH      = DEF_ADDR_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [VA_W-1:0]     in_virtual_address,
  input  logic [TS_W-1:0]     in_timestamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PA_OUT_W-1:0] out_physical_address,
  output logic                out_tlb_hit,
  output logic [1:0]          out_page_lookup,
  output logic                out_cache_hit
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  tlbpt_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  tlbpt_dp #(
    .MAX_TLB_ENTRIES(MAX_TLB_ENTRIES),
    .MAX_FRAMES     (MAX_FRAMES),
    .MAX_SETS       (MAX_SETS),
    .MAX_WAYS       (MAX_WAYS),
    .ADDR_WIDTH     (ADDR_WIDTH)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_virtual_address  (in_virtual_address),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_physical_address(out_physical_address),
    .out_tlb_hit         (out_tlb_hit),
    .out_page_lookup     (out_page_lookup),
    .out_cache_hit       (out_cache_hit)
  );

endmodule

// ===== hdl/tlbpt_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies beyond tlbpt_pkg
`timescale 1ns / 1ps

module tlbpt_ram
  import tlbpt_pkg::*;
#(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                    clk,
  input  logic                    we,
  input  logic [idx_w(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]        wdata,
  input  logic [idx_w(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hdl/tlbpt_ctrl.sv =====
// sequencing state machine for the simulator: clear, scan, update, sweep, cache lookup
// depends on tlbpt_pkg
`timescale 1ns / 1ps

module tlbpt_ctrl
  import tlbpt_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (sts.clr_done) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_UPD;
      ST_UPD:   state_nxt = ST_SWEEP;
      ST_SWEEP: if (sts.sweep_done) state_nxt = ST_LOOK;
      ST_LOOK:  if (sts.look_done) state_nxt = ST_CWR;
      ST_CWR:   state_nxt = ST_DONE;
      ST_DONE:  if (sts.out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr = 1'b1;
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_SCAN: cmd.scan = 1'b1;
      ST_UPD: begin
        cmd.upd    = 1'b1;
        cmd.ca_clr = 1'b1;
      end
      ST_SWEEP: begin
        cmd.sweep  = 1'b1;
        cmd.ca_clr = sts.sweep_done;
      end
      ST_LOOK:  cmd.look = 1'b1;
      ST_CWR:   cmd.cwr = 1'b1;
      ST_DONE:  cmd.outld = sts.out_free;
      default:  cmd = '0;
    endcase
  end

endmodule

// ===== hdl/tlbpt_dp.sv =====
// datapath: config registers, tlb and frame tables, cache line ram, output register
// depends on tlbpt_pkg and tlbpt_ram
`timescale 1ns / 1ps

module tlbpt_dp
  import tlbpt_pkg::*;
#(
  parameter int MAX_TLB_ENTRIES = DEF_MAX_TLB_ENTRIES,
  parameter int MAX_FRAMES      = DEF_MAX_FRAMES,
  parameter int MAX_SETS        = DEF_MAX_SETS,
  parameter int MAX_WAYS        = DEF_MAX_WAYS,
  parameter int ADDR_WIDTH      = DEF_ADDR_WIDTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  dp_cmd_t             cmd,
  output dp_sts_t             sts,
  input  logic                cfg_we,
  input  logic [CFG_IW-1:0]   cfg_index,
  input  logic [CFG_DW-1:0]   cfg_wdata,
  input  logic [VA_W-1:0]     in_virtual_address,
  input  logic [TS_W-1:0]     in_timestamp,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [PA_OUT_W-1:0] out_physical_address,
  output logic                out_tlb_hit,
  output logic [1:0]          out_page_lookup,
  output logic                out_cache_hit
);

  localparam int TLB_W  = idx_w(MAX_TLB_ENTRIES);
  localparam int FR_W   = idx_w(MAX_FRAMES);
  localparam int SET_W  = idx_w(MAX_SETS);
  localparam int WAY_W  = idx_w(MAX_WAYS);
  localparam int LINES  = MAX_SETS * MAX_WAYS;
  localparam int LA_W   = idx_w(LINES);
  localparam int NT_W   = $clog2(MAX_TLB_ENTRIES + 1);
  localparam int NF_W   = $clog2(MAX_FRAMES + 1);
  localparam int NW_W   = $clog2(MAX_WAYS + 1);
  localparam int SC_W   = (NT_W > NF_W) ? NT_W : NF_W;
  localparam int SB_CAP = $clog2(MAX_SETS + 1) - 1;
  localparam int VPN_W  = ADDR_WIDTH - 4;
  localparam int PA_W   = FR_W + 16;
  localparam int TAG_W  = PA_W - 2;
  localparam int BW     = TAG_W + 16;
  localparam int FW     = VPN_W + TS_W;
  localparam int LW     = 1 + TAG_W + TS_W;

  // configuration registers
  logic [4:0] page_bits_r;
  logic [3:0] block_bits_r;
  logic [3:0] set_bits_r;
  logic [3:0] ways_r;
  logic [4:0] tlb_n_r;
  logic [6:0] frames_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      page_bits_r  <= 5'd12;
      block_bits_r <= 4'd4;
      set_bits_r   <= 4'd4;
      ways_r       <= 4'd4;
      tlb_n_r      <= 5'd16;
      frames_n_r   <= 7'd64;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PAGE_BITS:  page_bits_r  <= cfg_wdata[4:0];
        CFG_BLOCK_BITS: block_bits_r <= cfg_wdata[3:0];
        CFG_SET_BITS:   set_bits_r   <= cfg_wdata[3:0];
        CFG_WAYS:       ways_r       <= cfg_wdata[3:0];
        CFG_TLB_N:      tlb_n_r      <= cfg_wdata[4:0];
        CFG_FRAMES_N:   frames_n_r   <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // saturated working values
  logic [4:0]      pb;
  logic [3:0]      bb;
  logic [3:0]      sb;
  logic [NW_W-1:0] ways_c;
  logic [NT_W-1:0] ntlb;
  logic [NF_W-1:0] nfr;
  logic [SC_W-1:0] scan_n;

  always_comb begin
    if (page_bits_r < 5'd4) pb = 5'd4;
    else if (page_bits_r > 5'd16) pb = 5'd16;
    else pb = page_bits_r;

    if (block_bits_r < 4'd2) bb = 4'd2;
    else if (block_bits_r > 4'd8) bb = 4'd8;
    else bb = block_bits_r;
    if ({1'b0, bb} > pb) bb = pb[3:0];

    if (set_bits_r > 4'd8) sb = 4'd8;
    else sb = set_bits_r;
    if (int'(sb) > SB_CAP) sb = 4'(SB_CAP);

    if (ways_r == 4'd0) ways_c = NW_W'(1);
    else if (int'(ways_r) > MAX_WAYS) ways_c = NW_W'(MAX_WAYS);
    else ways_c = NW_W'(ways_r);

    if (tlb_n_r == 5'd0) ntlb = NT_W'(1);
    else if (int'(tlb_n_r) > MAX_TLB_ENTRIES) ntlb = NT_W'(MAX_TLB_ENTRIES);
    else ntlb = NT_W'(tlb_n_r);

    if (frames_n_r == 7'd0) nfr = NF_W'(1);
    else if (int'(frames_n_r) > MAX_FRAMES) nfr = NF_W'(MAX_FRAMES);
    else nfr = NF_W'(frames_n_r);

    scan_n = (SC_W'(ntlb) > SC_W'(nfr)) ? SC_W'(ntlb) : SC_W'(nfr);
  end

  // request capture
  logic [ADDR_WIDTH-1:0] va_r;
  logic [TS_W-1:0]       ts_r;
  logic [VPN_W-1:0]      vpn;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      va_r <= in_virtual_address[ADDR_WIDTH-1:0];
      ts_r <= in_timestamp;
    end
  end

  assign vpn = VPN_W'(va_r >> pb);

  // tlb storage in flops
  logic             tlb_valid_r [MAX_TLB_ENTRIES];
  logic [VPN_W-1:0] tlb_page_r  [MAX_TLB_ENTRIES];
  logic [TS_W-1:0]  tlb_last_r  [MAX_TLB_ENTRIES];
  logic             fv_r        [MAX_FRAMES];

  // scan of tlb and frame table, frame table read data arriving the cycle after its address
  logic [SC_W-1:0]  cnt_r;
  logic             s_vld_r;
  logic [SC_W-1:0]  s_idx_r;
  logic             scan_issue;
  logic [TLB_W-1:0] ti;
  logic [FR_W-1:0]  fi;
  logic             in_t, in_f;
  logic [FW-1:0]    fr_rdata;
  logic [VPN_W-1:0] f_page_rd;
  logic [TS_W-1:0]  f_last_rd;

  assign scan_issue = cmd.scan && (cnt_r != scan_n);
  assign ti         = s_idx_r[TLB_W-1:0];
  assign fi         = s_idx_r[FR_W-1:0];
  assign in_t       = s_vld_r && (s_idx_r < SC_W'(ntlb));
  assign in_f       = s_vld_r && (s_idx_r < SC_W'(nfr));
  assign f_page_rd  = fr_rdata[FW-1:TS_W];
  assign f_last_rd  = fr_rdata[TS_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      s_vld_r <= 1'b0;
    end else if (cmd.load) begin
      cnt_r   <= '0;
      s_vld_r <= 1'b0;
    end else begin
      s_vld_r <= scan_issue;
      if (scan_issue) cnt_r <= cnt_r + SC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (scan_issue) s_idx_r <= cnt_r;
  end

  logic             t_hit_r, t_emp_r, f_hit_r, f_emp_r;
  logic [TLB_W-1:0] t_hidx_r, t_eidx_r, t_bidx_r;
  logic [TS_W-1:0]  t_blast_r, f_blast_r;
  logic [FR_W-1:0]  f_hidx_r, f_eidx_r, f_bidx_r;
  logic [VPN_W-1:0] f_bpage_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      t_hit_r <= 1'b0;
      t_emp_r <= 1'b0;
      f_hit_r <= 1'b0;
      f_emp_r <= 1'b0;
    end else if (cmd.load) begin
      t_hit_r <= 1'b0;
      t_emp_r <= 1'b0;
      f_hit_r <= 1'b0;
      f_emp_r <= 1'b0;
    end else begin
      if (in_t) begin
        if (tlb_valid_r[ti] && (tlb_page_r[ti] == vpn) && !t_hit_r) begin
          t_hit_r  <= 1'b1;
          t_hidx_r <= ti;
        end
        if (!tlb_valid_r[ti] && !t_emp_r) begin
          t_emp_r  <= 1'b1;
          t_eidx_r <= ti;
        end
        if ((s_idx_r == '0) || (tlb_last_r[ti] < t_blast_r)) begin
          t_bidx_r  <= ti;
          t_blast_r <= tlb_last_r[ti];
        end
      end
      if (in_f) begin
        if (fv_r[fi] && (f_page_rd == vpn) && !f_hit_r) begin
          f_hit_r  <= 1'b1;
          f_hidx_r <= fi;
        end
        if (!fv_r[fi] && !f_emp_r) begin
          f_emp_r  <= 1'b1;
          f_eidx_r <= fi;
        end
        if ((s_idx_r == '0) || (f_last_rd < f_blast_r)) begin
          f_bidx_r  <= fi;
          f_blast_r <= f_last_rd;
          f_bpage_r <= f_page_rd;
        end
      end
    end
  end

  // table update
  logic [TLB_W-1:0] t_widx;
  logic [FR_W-1:0]  f_widx;
  logic [PA_W-1:0]  pa_nxt;
  logic [15:0]      off_mask;

  assign t_widx   = t_hit_r ? t_hidx_r : (t_emp_r ? t_eidx_r : t_bidx_r);
  assign f_widx   = f_hit_r ? f_hidx_r : (f_emp_r ? f_eidx_r : f_bidx_r);
  assign off_mask = 16'((32'(1) << pb) - 32'(1));
  assign pa_nxt   = (PA_W'(f_widx) << pb) | PA_W'(va_r[15:0] & off_mask);

  logic             need_r;
  logic [FR_W-1:0]  frame_r;
  logic [VPN_W-1:0] old_vpn_r;
  logic [PA_W-1:0]  pa_r;
  logic             tlb_hit_r;
  lookup_t          look_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      need_r <= 1'b0;
    end else if (cmd.upd) begin
      need_r <= !t_hit_r && !f_hit_r && !f_emp_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.upd) begin
      frame_r   <= f_widx;
      old_vpn_r <= f_bpage_r;
      pa_r      <= pa_nxt;
      tlb_hit_r <= t_hit_r;
      if (t_hit_r) look_r <= LK_SKIP;
      else if (f_hit_r) look_r <= LK_HIT;
      else if (f_emp_r) look_r <= LK_FILL;
      else look_r <= LK_EVICT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_TLB_ENTRIES; i++) tlb_valid_r[i] <= 1'b0;
    end else begin
      if (cmd.upd) begin
        tlb_valid_r[t_widx] <= 1'b1;
        tlb_page_r[t_widx]  <= vpn;
        tlb_last_r[t_widx]  <= ts_r;
      end
      // drop the tlb mapping of the evicted page
      if (cmd.sweep && need_r) begin
        for (int i = 0; i < MAX_TLB_ENTRIES; i++) begin
          if ((NT_W'(i) < ntlb) && tlb_valid_r[i] && (tlb_page_r[i] == old_vpn_r)) begin
            tlb_valid_r[i] <= 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_FRAMES; i++) fv_r[i] <= 1'b0;
    end else if (cmd.upd) begin
      fv_r[f_widx] <= 1'b1;
    end
  end

  tlbpt_ram #(
    .WIDTH(FW),
    .DEPTH(MAX_FRAMES)
  ) u_frame_ram (
    .clk  (clk),
    .we   (cmd.upd),
    .waddr(f_widx),
    .wdata({vpn, ts_r}),
    .raddr(cnt_r[FR_W-1:0]),
    .rdata(fr_rdata)
  );

  // cache line walk, shared by the frame sweep and the set lookup
  function automatic logic [LA_W-1:0] line_addr(input logic [SET_W-1:0] s,
                                                 input logic [WAY_W-1:0] w);
    return LA_W'(32'(s) * MAX_WAYS + 32'(w));
  endfunction

  logic [SET_W-1:0] set_mask;
  logic [PA_W-1:0]  blk;
  logic [SET_W-1:0] cset;
  logic [TAG_W-1:0] ctag;

  assign set_mask = SET_W'((32'(1) << sb) - 32'(1));
  assign blk      = pa_r >> bb;
  assign cset     = SET_W'(blk) & set_mask;
  assign ctag     = TAG_W'(blk >> sb);

  logic [SET_W-1:0] ca_set_r, p_set_r, rd_set;
  logic [WAY_W-1:0] ca_way_r, p_way_r;
  logic             ca_end_r, p_vld_r;
  logic             sweep_issue, look_issue, way_last;
  logic [LW-1:0]    line_rdata;

  assign sweep_issue = cmd.sweep && need_r && !ca_end_r;
  assign look_issue  = cmd.look && !ca_end_r;
  assign way_last    = (NW_W'(ca_way_r) == (ways_c - NW_W'(1)));
  assign rd_set      = cmd.look ? cset : ca_set_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ca_clr) begin
      ca_set_r <= '0;
      ca_way_r <= '0;
      ca_end_r <= 1'b0;
      p_vld_r  <= 1'b0;
    end else begin
      p_vld_r <= sweep_issue || look_issue;
      if (sweep_issue || look_issue) begin
        if (way_last) begin
          ca_way_r <= '0;
          if (look_issue || (ca_set_r == set_mask)) ca_end_r <= 1'b1;
          else ca_set_r <= ca_set_r + SET_W'(1);
        end else begin
          ca_way_r <= ca_way_r + WAY_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sweep_issue || look_issue) begin
      p_set_r <= rd_set;
      p_way_r <= ca_way_r;
    end
  end

  logic             l_val;
  logic [TAG_W-1:0] l_tag;
  logic [TS_W-1:0]  l_last;
  logic [BW-1:0]    bx, byte_addr;
  logic             sw_we;

  assign l_val     = line_rdata[LW-1];
  assign l_tag     = line_rdata[LW-2:TS_W];
  assign l_last    = line_rdata[TS_W-1:0];
  assign bx        = (BW'(l_tag) << sb) | BW'(p_set_r);
  assign byte_addr = bx << bb;
  // every line walked is tested, valid or not
  assign sw_we     = cmd.sweep && p_vld_r && ((byte_addr >> pb) == BW'(frame_r));

  // set lookup: first hit, else first empty way, else oldest way
  logic             c_hit_r, c_emp_r;
  logic [WAY_W-1:0] c_hidx_r, c_eidx_r, c_bidx_r, c_widx;
  logic [TS_W-1:0]  c_blast_r;
  logic             chit_r;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.ca_clr) begin
      c_hit_r <= 1'b0;
      c_emp_r <= 1'b0;
    end else if (cmd.look && p_vld_r) begin
      if (l_val && (l_tag == ctag) && !c_hit_r) begin
        c_hit_r  <= 1'b1;
        c_hidx_r <= p_way_r;
      end
      if (!l_val && !c_emp_r) begin
        c_emp_r  <= 1'b1;
        c_eidx_r <= p_way_r;
      end
      if ((p_way_r == '0) || (l_last < c_blast_r)) begin
        c_bidx_r  <= p_way_r;
        c_blast_r <= l_last;
      end
    end
  end

  assign c_widx = c_hit_r ? c_hidx_r : (c_emp_r ? c_eidx_r : c_bidx_r);

  always_ff @(posedge clk) begin
    if (cmd.cwr) chit_r <= c_hit_r;
  end

  // clearing pass after reset
  logic [LA_W-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clr) begin
      clr_cnt_r <= clr_cnt_r + LA_W'(1);
    end
  end

  logic            l_we;
  logic [LA_W-1:0] l_waddr;
  logic [LW-1:0]   l_wdata;

  always_comb begin
    l_we    = 1'b0;
    l_waddr = clr_cnt_r;
    l_wdata = '0;
    priority if (cmd.clr) begin
      l_we = 1'b1;
    end else if (sw_we) begin
      l_we    = 1'b1;
      l_waddr = line_addr(p_set_r, p_way_r);
      l_wdata = {1'b0, l_tag, l_last};
    end else if (cmd.cwr) begin
      l_we    = 1'b1;
      l_waddr = line_addr(cset, c_widx);
      l_wdata = {1'b1, ctag, ts_r};
    end
  end

  tlbpt_ram #(
    .WIDTH(LW),
    .DEPTH(LINES)
  ) u_line_ram (
    .clk  (clk),
    .we   (l_we),
    .waddr(l_waddr),
    .wdata(l_wdata),
    .raddr(line_addr(rd_set, ca_way_r)),
    .rdata(line_rdata)
  );

  // output register
  logic                out_valid_r;
  logic [PA_OUT_W-1:0] out_pa_r;
  logic                out_tlb_hit_r;
  lookup_t             out_look_r;
  logic                out_chit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.outld) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.outld) begin
      out_pa_r      <= PA_OUT_W'(pa_r);
      out_tlb_hit_r <= tlb_hit_r;
      out_look_r    <= look_r;
      out_chit_r    <= chit_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_physical_address = out_pa_r;
  assign out_tlb_hit          = out_tlb_hit_r;
  assign out_page_lookup      = out_look_r;
  assign out_cache_hit        = out_chit_r;

  always_comb begin
    sts            = '0;
    sts.clr_done   = cmd.clr && (clr_cnt_r == LA_W'(LINES - 1));
    sts.scan_done  = (cnt_r == scan_n) && !s_vld_r;
    sts.sweep_done = !need_r || (ca_end_r && !p_vld_r);
    sts.look_done  = ca_end_r && !p_vld_r;
    sts.out_free   = !out_valid_r || out_ready;
  end

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.outld |-> (!out_valid_r || out_ready))
    else $error("result register overwritten while pending");

  a_scan_drained: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.upd |-> !s_vld_r)
    else $error("table update before scan pipeline drained");

  a_line_read_src: assert property (@(posedge clk) disable iff (!rst_n)
    p_vld_r |-> $past(cmd.sweep || cmd.look))
    else $error("line read pipeline fed outside sweep or lookup");

  a_cwr_idle_walk: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.cwr |-> (!p_vld_r && !sw_we))
    else $error("line write collides with walk");

endmodule

// ===== verif/tlb_page_table_cache_lru_sim_tb.sv =====
// testbench for tlb_page_table_cache_lru_sim: tlb, inverted page table and lru cache
// depends on tlbpt_pkg and the rtl under hdl/; predicts every result and checks it
`timescale 1ns / 1ps

module tlb_page_table_cache_lru_sim_tb;
  import tlbpt_pkg::*;

  localparam int N_TLB   = DEF_MAX_TLB_ENTRIES;
  localparam int N_FRM   = DEF_MAX_FRAMES;
  localparam int N_WAYS  = DEF_MAX_WAYS;
  localparam int N_LINES = DEF_MAX_SETS * DEF_MAX_WAYS;

  // one table entry: used for tlb, frame table and cache lines alike
  typedef struct {
    bit          valid;
    logic [31:0] key;
    logic [31:0] stamp;
  } slot_t;

  typedef struct {
    logic [VA_W-1:0] va;
    logic [TS_W-1:0] ts;
  } access_t;

  typedef struct {
    logic [PA_OUT_W-1:0] pa;
    logic                tlb_hit;
    lookup_t             lk;
    logic                cache_hit;
  } xlate_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [VA_W-1:0]     in_virtual_address;
  logic [TS_W-1:0]     in_timestamp;
  logic                out_valid;
  logic                out_ready;
  logic [PA_OUT_W-1:0] out_physical_address;
  logic                out_tlb_hit;
  logic [1:0]          out_page_lookup;
  logic                out_cache_hit;

  tlb_page_table_cache_lru_sim u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_virtual_address  (in_virtual_address),
    .in_timestamp        (in_timestamp),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_physical_address(out_physical_address),
    .out_tlb_hit         (out_tlb_hit),
    .out_page_lookup     (out_page_lookup),
    .out_cache_hit       (out_cache_hit)
  );

  // 12 ns clock
  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // shadow register copies, raw as written (clamped when used)
  logic [4:0] sh_page_bits;
  logic [3:0] sh_block_bits;
  logic [3:0] sh_set_bits;
  logic [3:0] sh_ways;
  logic [4:0] sh_tlb_n;
  logic [6:0] sh_frames_n;

  // shadow tables
  slot_t tlb_tab  [N_TLB];
  slot_t frame_tab[N_FRM];
  slot_t line_tab [N_LINES];

  access_t pending_reqs[$];
  xlate_t  expected_xlates[$];

  int unsigned snd_idle_pct;
  int unsigned rcv_idle_pct;
  bit          long_hold_req;
  bit          long_hold_done;
  int unsigned hold_cnt;
  int unsigned mismatches;
  logic [31:0] stamp_now;
  xlate_t      pred_x;
  xlate_t      got_x;
  access_t     next_req;

  function automatic int unsigned clampu(input int unsigned v, lo, hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // hit first, then first empty entry, then oldest stamp (lowest index on tie)
  function automatic int pick_slot(input slot_t cand[$], input logic [31:0] k,
                                   output int how);
    int best;
    best = 0;
    foreach (cand[i])
      if (cand[i].valid && cand[i].key == k) begin
        how = 1;
        return i;
      end
    foreach (cand[i])
      if (!cand[i].valid) begin
        how = 2;
        return i;
      end
    for (int i = 1; i < cand.size(); i++)
      if (cand[i].stamp < cand[best].stamp) best = i;
    how = 3;
    return best;
  endfunction

  // translate one request and update the shadow tables
  function automatic xlate_t translate(input access_t a);
    int unsigned pb, bb, sb, ways, ntlb, nfr, nsets, set_i, base;
    int          tlb_how, pt_how, c_how, ti, fi, ci;
    logic [31:0] vpn, old_vpn, tag;
    logic [63:0] pa, blk, byte_a;
    slot_t       cand[$];
    xlate_t      x;
    pb    = clampu(sh_page_bits, 4, 16);
    bb    = clampu(sh_block_bits, 2, 8);
    sb    = clampu(sh_set_bits, 0, 8);
    ways  = clampu(sh_ways, 1, N_WAYS);
    ntlb  = clampu(sh_tlb_n, 1, N_TLB);
    nfr   = clampu(sh_frames_n, 1, N_FRM);
    if (bb > pb) bb = pb;
    nsets = 1 << sb;
    vpn   = a.va >> pb;

    cand = {};
    for (int i = 0; i < ntlb; i++) cand.push_back(tlb_tab[i]);
    ti = pick_slot(cand, vpn, tlb_how);
    tlb_tab[ti] = '{1'b1, vpn, a.ts};

    cand = {};
    for (int i = 0; i < nfr; i++) cand.push_back(frame_tab[i]);
    fi = pick_slot(cand, vpn, pt_how);
    old_vpn = frame_tab[fi].key;
    frame_tab[fi] = '{1'b1, vpn, a.ts};
    pa = (64'(fi) << pb) | (64'(a.va) & ((64'd1 << pb) - 1));

    x.tlb_hit = (tlb_how == 1);
    if (tlb_how == 1) begin
      x.lk = LK_SKIP;
    end else begin
      x.lk = lookup_t'(pt_how);
      if (pt_how == 3) begin
        // drop every cached block of the evicted frame, then its tlb entry
        for (int s = 0; s < nsets; s++)
          for (int w = 0; w < ways; w++) begin
            byte_a = ((64'(line_tab[s*N_WAYS+w].key) << sb) | 64'(s)) << bb;
            if ((byte_a >> pb) == 64'(fi)) line_tab[s*N_WAYS+w].valid = 1'b0;
          end
        for (int i = 0; i < ntlb; i++)
          if (tlb_tab[i].valid && tlb_tab[i].key == old_vpn) tlb_tab[i].valid = 1'b0;
      end
    end

    blk   = pa >> bb;
    set_i = blk & (nsets - 1);
    tag   = blk >> sb;
    base  = set_i * N_WAYS;
    cand = {};
    for (int w = 0; w < ways; w++) cand.push_back(line_tab[base+w]);
    ci = pick_slot(cand, tag, c_how);
    line_tab[base+ci] = '{1'b1, tag, a.ts};
    x.cache_hit = (c_how == 1);
    x.pa = pa[PA_OUT_W-1:0];
    return x;
  endfunction

  // driver: predicts at acceptance, then offers the next pending request
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        next_req.va = in_virtual_address;
        next_req.ts = in_timestamp;
        expected_xlates.push_back(translate(next_req));
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= snd_idle_pct) begin
          next_req            = pending_reqs.pop_front();
          in_valid           <= 1'b1;
          in_virtual_address <= next_req.va;
          in_timestamp       <= next_req.ts;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: checks each accepted result and drives out_ready
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready      <= 1'b0;
      hold_cnt       <= 0;
      long_hold_done <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_x.pa        = out_physical_address;
        got_x.tlb_hit   = out_tlb_hit;
        got_x.lk        = lookup_t'(out_page_lookup);
        got_x.cache_hit = out_cache_hit;
        if (expected_xlates.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: unexpected result pa=%h tlb=%b lk=%0d cache=%b", $time,
                     got_x.pa, got_x.tlb_hit, got_x.lk, got_x.cache_hit);
        end else begin
          pred_x = expected_xlates.pop_front();
          if (got_x.pa !== pred_x.pa || got_x.tlb_hit !== pred_x.tlb_hit ||
              got_x.lk !== pred_x.lk || got_x.cache_hit !== pred_x.cache_hit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("%0t: mismatch exp pa=%h tlb=%b lk=%0d cache=%b got pa=%h tlb=%b lk=%0d cache=%b",
                       $time, pred_x.pa, pred_x.tlb_hit, pred_x.lk, pred_x.cache_hit,
                       got_x.pa, got_x.tlb_hit, got_x.lk, got_x.cache_hit);
          end
        end
      end
      // one long hold-off so the block fills and stalls its input
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_cnt       <= 600;
        out_ready      <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt  <= hold_cnt - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rcv_idle_pct);
      end
    end
  end

  // register write, shadow copy updated at the same time
  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_PAGE_BITS:  sh_page_bits  = val[4:0];
      CFG_BLOCK_BITS: sh_block_bits = val[3:0];
      CFG_SET_BITS:   sh_set_bits   = val[3:0];
      CFG_WAYS:       sh_ways       = val[3:0];
      CFG_TLB_N:      sh_tlb_n      = val[4:0];
      CFG_FRAMES_N:   sh_frames_n   = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_all(input logic [CFG_DW-1:0] pb, bb, sb, wy, nt, nf);
    write_reg(CFG_PAGE_BITS, pb);
    write_reg(CFG_BLOCK_BITS, bb);
    write_reg(CFG_SET_BITS, sb);
    write_reg(CFG_WAYS, wy);
    write_reg(CFG_TLB_N, nt);
    write_reg(CFG_FRAMES_N, nf);
  endtask

  task automatic push_req(input logic [31:0] va, ts);
    access_t a;
    a.va = va;
    a.ts = ts;
    pending_reqs.push_back(a);
  endtask

  // requests on a small pool of pages, with some fully random noise
  task automatic push_pages(input int n, input int unsigned npages, base);
    int unsigned pb;
    logic [31:0] vpn;
    pb = clampu(sh_page_bits, 4, 16);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < 10) begin
        push_req($urandom, $urandom);
      end else begin
        vpn = base + $urandom_range(npages - 1);
        stamp_now += $urandom_range(1, 4);
        push_req((vpn << pb) | ($urandom & ((32'd1 << pb) - 1)), stamp_now);
      end
    end
  endtask

  // wait until every request has been answered, then let the bench idle
  task automatic drain;
    while (pending_reqs.size() > 0 || in_valid || expected_xlates.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  initial begin
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = CFG_PAGE_BITS;
    cfg_wdata          = '0;
    in_valid           = 1'b0;
    in_virtual_address = '0;
    in_timestamp       = '0;
    out_ready          = 1'b0;
    long_hold_req      = 1'b0;
    mismatches         = 0;
    stamp_now          = 32'd100;
    sh_page_bits       = 5'd12;
    sh_block_bits      = 4'd4;
    sh_set_bits        = 4'd4;
    sh_ways            = 4'd4;
    sh_tlb_n           = 5'd16;
    sh_frames_n        = 7'd64;
    foreach (tlb_tab[i])   tlb_tab[i]   = '{1'b0, '0, '0};
    foreach (frame_tab[i]) frame_tab[i] = '{1'b0, '0, '0};
    foreach (line_tab[i])  line_tab[i]  = '{1'b0, '0, '0};
    snd_idle_pct = 22;
    rcv_idle_pct = 82;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: address and stamp extremes, same page, next block, repeats
    push_req(32'h0000_0000, 32'h0000_0000);
    push_req(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_req(32'h0000_0010, 32'd5);
    push_req(32'h0000_0000, 32'd6);
    push_req(32'h0000_1000, 32'd7);
    push_req(32'hFFFF_FFF0, 32'd8);
    push_req(32'h0000_1004, 32'd9);
    push_req(32'h8000_0000, 32'd10);
    push_req(32'h7FFF_FFFF, 32'd11);
    push_pages(300, 80, 3);
    drain();

    // smallest legal settings: one way, one set, one tlb entry, one frame
    set_all(4, 2, 0, 1, 1, 1);
    push_pages(150, 4, 0);
    drain();

    // below range, saturates upward
    set_all(0, 0, 0, 0, 0, 0);
    push_pages(100, 5, 9);
    drain();

    // largest settings: sweeps cover all 2048 lines, so keep this short
    set_all(16, 8, 8, 8, 16, 64);
    push_pages(60, 70, 1);
    drain();

    // above range, saturates downward
    set_all(7'd31, 7'd15, 7'd15, 7'd15, 7'd31, 7'd127);
    push_pages(40, 70, 2);
    drain();

    // tlb still holds pages whose frames go out of use: tlb hit, table miss
    set_all(12, 4, 4, 4, 16, 64);
    for (int p = 0; p < 8; p++) push_req(32'h0010_0000 + (p << 12), stamp_now + p);
    stamp_now += 16;
    drain();
    write_reg(CFG_FRAMES_N, 2);
    for (int p = 0; p < 8; p++) push_req(32'h0010_0000 + (p << 12) + 4, stamp_now + p);
    stamp_now += 16;
    drain();

    // mid settings, idle ratios swapped
    set_all(8, 4, 3, 2, 4, 8);
    snd_idle_pct = 82;
    rcv_idle_pct = 22;
    push_pages(600, 12, 20);
    drain();

    // no idling; one long receiver hold while requests keep coming
    snd_idle_pct  = 0;
    rcv_idle_pct  = 0;
    long_hold_req = 1'b1;
    push_pages(400, 12, 20);
    drain();
    repeat (100) @(posedge clk);

    if (mismatches == 0 && expected_xlates.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // watchdog
  initial begin
    #60_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
